FILE: rtl/rtp_reorder_buffer_macros.svh
// Assertion macros shared by the reorder buffer RTL.
`ifndef RTP_REORDER_BUFFER_MACROS_SVH
`define RTP_REORDER_BUFFER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, quiet during reset.
`define RTPRB_ASSERT_IMP(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("reorder buffer assertion failed");
// Next-cycle implication, sampled on clk, quiet during reset.
`define RTPRB_ASSERT_NEXT(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("reorder buffer assertion failed");
`else
`define RTPRB_ASSERT_IMP(lbl, cond, prop)
`define RTPRB_ASSERT_NEXT(lbl, cond, prop)
`endif

`endif

FILE: rtl/rtprb_pkg.sv
// Types and constants of the RTP reorder buffer.
`default_nettype none
package rtprb_pkg;

	// Header checks
	localparam int unsigned HDR_LEN     = 12;
	localparam int unsigned PAYLOAD_MAX = 2048;
	localparam logic [1:0]  RTP_VERSION = 2'd2;
	localparam logic [15:0] SEQ_TOP     = 16'hFFFF;

	// Result status codes
	localparam logic [2:0] STAT_TOO_SHORT = 3'd0;
	localparam logic [2:0] STAT_BAD_VER   = 3'd1;
	localparam logic [2:0] STAT_TOO_LONG  = 3'd2;
	localparam logic [2:0] STAT_STORED    = 3'd3;
	localparam logic [2:0] STAT_RELEASED  = 3'd4;

	// Register map
	localparam logic       REG_ACTIVE_DEPTH   = 1'b0;
	localparam logic [5:0] ACTIVE_DEPTH_RESET = 6'd32;

	typedef struct packed {
		logic [7:0]  first_byte;
		logic [7:0]  second_byte;
		logic [15:0] seq_num;
		logic [31:0] rtp_time;
		logic [31:0] source_id;
		logic [11:0] packet_length;
		logic [7:0]  pad_count;
		logic [15:0] payload_ref;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [6:0]  rel_type;
		logic [15:0] rel_seq;
		logic [31:0] rel_time;
		logic [11:0] rel_length;
		logic [15:0] rel_ref;
		logic [31:0] ext_seq;
		logic [31:0] last_source;
		logic        marker;
	} result_t;

	// One table entry held in a cell
	typedef struct packed {
		logic [6:0]  pt;
		logic [15:0] sq;
		logic [31:0] ts;
		logic [11:0] len;
		logic [15:0] pref;
	} entry_t;

	// Search candidate handed from cell to cell
	typedef struct packed {
		logic        valid;
		logic        has_top;
		logic        found1;
		logic [15:0] best1;
		logic        found2;
		logic [15:0] best2;
	} scan_t;

endpackage
`default_nettype wire

FILE: rtl/rtp_reorder_buffer.sv
// Top level of the RTP reorder buffer: header checks, sequence tracking, cell chain.
//
// channel  | handshake             | payload
// ---------+-----------------------+------------------------
// item in  | start & !busy         | pkt   (rtprb_pkg::item_t)
// result   | done, one cycle       | res   (rtprb_pkg::result_t)
// config   | psel & penable & pwrite | paddr, pwdata, prdata
//
// An item is taken when start is high and busy is low; busy stays high until its result.
// Dropped or stored items are decided in the evaluation state and their result is registered.
// A release walks the cell chain one cell a cycle from the highest entry in use down to
// entry 0, where the highest entry is active_depth held to 1..DEPTH, less one; the result
// is registered as the search leaves entry 0.
// Reset clears control state, counters and the active_depth register; table entries are
// left as they are and are only read after being written. The receiver cannot stall.
`default_nettype none
`include "rtp_reorder_buffer_macros.svh"
module rtp_reorder_buffer #(
	parameter int DEPTH = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire rtprb_pkg::item_t  pkt,
	output logic                   done,
	output rtprb_pkg::result_t     res,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	import rtprb_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EVAL = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;

	logic [1:0]       state_q;
	item_t            pkt_q;
	result_t          res_q;
	logic             done_q;
	logic [5:0]       active_depth_q;
	logic [CNT_W-1:0] fill_q;
	logic [15:0]      wrap_q;
	logic [15:0]      seq_low_q;
	logic [31:0]      source_q;

	// configuration port
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ACTIVE_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_depth_q <= ACTIVE_DEPTH_RESET;
		end else if (cfg_wr) begin
			active_depth_q <= pwdata[5:0];
		end
	end

	assign prdata = (paddr[2] == REG_ACTIVE_DEPTH) ? {26'd0, active_depth_q} : 32'd0;

	// clamp the depth to 1..DEPTH
	logic [CMP_W-1:0] ad_ext, eff_w;
	logic [CNT_W-1:0] eff;
	logic [IDX_W-1:0] inj_idx;
	always_comb begin
		ad_ext = CMP_W'(active_depth_q);
		if (ad_ext == '0) begin
			eff_w = CMP_W'(1);
		end else if (ad_ext > CMP_W'(DEPTH)) begin
			eff_w = CMP_W'(DEPTH);
		end else begin
			eff_w = ad_ext;
		end
		eff     = CNT_W'(eff_w);
		inj_idx = IDX_W'(eff - CNT_W'(1));
	end

	// header checks on the held item
	logic [11:0] len, len2, plen;
	logic [11:0] pad_ext;
	logic        pad_on, pad_big, is_short, bad_ver, too_long, keep;
	logic [2:0]  drop_code;
	always_comb begin
		len      = pkt_q.packet_length;
		pad_ext  = {4'd0, pkt_q.pad_count};
		pad_on   = pkt_q.first_byte[5];
		pad_big  = pad_ext > len;
		len2     = (pad_on && !pad_big) ? (len - pad_ext) : len;
		bad_ver  = pkt_q.first_byte[7:6] != RTP_VERSION;
		is_short = (len < 12'(HDR_LEN)) ||
			(pad_on && (pad_big || (len2 < 12'(HDR_LEN))));
		plen     = len2 - 12'(HDR_LEN);
		too_long = {1'b0, plen} > 13'(PAYLOAD_MAX);
		keep     = 1'b0;
		if (len < 12'(HDR_LEN)) begin
			drop_code = STAT_TOO_SHORT;
		end else if (bad_ver) begin
			drop_code = STAT_BAD_VER;
		end else if (is_short) begin
			drop_code = STAT_TOO_SHORT;
		end else if (too_long) begin
			drop_code = STAT_TOO_LONG;
		end else begin
			drop_code = STAT_STORED;
			keep      = 1'b1;
		end
	end

	// sequence tracking after this item
	logic [15:0] wrap_nx;
	assign wrap_nx = wrap_q + ((pkt_q.seq_num == 16'd0) ? 16'd1 : 16'd0);

	// cell chain
	scan_t            chain_in  [DEPTH];
	scan_t            chain_out [DEPTH];
	logic [IDX_W-1:0] idx1_in   [DEPTH];
	logic [IDX_W-1:0] idx2_in   [DEPTH];
	logic [IDX_W-1:0] idx1_out  [DEPTH];
	logic [IDX_W-1:0] idx2_out  [DEPTH];
	entry_t           ent       [DEPTH];
	logic             scan_go;
	logic             wr_go;
	logic [IDX_W-1:0] wr_idx;
	entry_t           wr_data;
	scan_t            scan_init;

	always_comb begin
		scan_init       = '0;
		scan_init.valid = 1'b1;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		scan_t            upper;
		logic [IDX_W-1:0] up1, up2;
		if (i == DEPTH - 1) begin : g_top
			assign upper = '0;
			assign up1   = '0;
			assign up2   = '0;
		end else begin : g_mid
			assign upper = chain_out[i+1];
			assign up1   = idx1_out[i+1];
			assign up2   = idx2_out[i+1];
		end
		// start the search at the highest entry in use
		assign chain_in[i] = (scan_go && (inj_idx == IDX_W'(i))) ? scan_init : upper;
		assign idx1_in[i]  = up1;
		assign idx2_in[i]  = up2;

		rtprb_cell #(
			.IDX_W (IDX_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(i)),
			.wr_en    (wr_go && (wr_idx == IDX_W'(i))),
			.wr_data  (wr_data),
			.entry    (ent[i]),
			.scan_in  (chain_in[i]),
			.idx1_in  (idx1_in[i]),
			.idx2_in  (idx2_in[i]),
			.scan_out (chain_out[i]),
			.idx1_out (idx1_out[i]),
			.idx2_out (idx2_out[i])
		);
	end

	logic             chain_done;
	logic [IDX_W-1:0] vic_idx;
	entry_t           victim;
	assign chain_done = chain_out[0].valid;
	assign vic_idx    = chain_out[0].has_top ? idx2_out[0] : idx1_out[0];
	assign victim     = ent[vic_idx];

	always_comb begin
		wr_data.pt   = pkt_q.second_byte[6:0];
		wr_data.sq   = pkt_q.seq_num;
		wr_data.ts   = pkt_q.rtp_time;
		wr_data.len  = plen;
		wr_data.pref = pkt_q.payload_ref;
	end

	// sequencer decisions
	logic eval_drop, eval_store, scan_end;
	always_comb begin
		eval_drop  = (state_q == ST_EVAL) && !keep;
		eval_store = (state_q == ST_EVAL) && keep && (fill_q < eff);
		scan_go    = (state_q == ST_EVAL) && keep && !(fill_q < eff);
		scan_end   = (state_q == ST_SCAN) && chain_done;
		wr_go      = eval_store || scan_end;
		wr_idx     = eval_store ? fill_q[IDX_W-1:0] : vic_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			done_q    <= 1'b0;
			fill_q    <= '0;
			wrap_q    <= '0;
			seq_low_q <= '0;
			source_q  <= '0;
		end else begin
			done_q <= eval_drop || eval_store || scan_end;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					state_q <= scan_go ? ST_SCAN : ST_IDLE;
				end
				ST_SCAN: begin
					if (chain_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (eval_store) begin
				fill_q <= fill_q + CNT_W'(1);
			end
			// commit sequence state for a kept item
			if (eval_store || scan_end) begin
				wrap_q    <= wrap_nx;
				seq_low_q <= pkt_q.seq_num;
				source_q  <= pkt_q.source_id;
			end
		end
	end

	// hold the accepted item
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			pkt_q <= pkt;
		end
	end

	// build the result
	always_ff @(posedge clk) begin
		if (eval_drop || eval_store || scan_end) begin
			res_q.marker <= pkt_q.second_byte[7];
			if (eval_drop) begin
				res_q.status      <= drop_code;
				res_q.ext_seq     <= {wrap_q, seq_low_q};
				res_q.last_source <= source_q;
			end else begin
				res_q.status      <= eval_store ? STAT_STORED : STAT_RELEASED;
				res_q.ext_seq     <= {wrap_nx, pkt_q.seq_num};
				res_q.last_source <= pkt_q.source_id;
			end
			// report the released entry, zero otherwise
			if (scan_end) begin
				res_q.rel_type   <= victim.pt;
				res_q.rel_seq    <= victim.sq;
				res_q.rel_time   <= victim.ts;
				res_q.rel_length <= victim.len;
				res_q.rel_ref    <= victim.pref;
			end else begin
				res_q.rel_type   <= '0;
				res_q.rel_seq    <= '0;
				res_q.rel_time   <= '0;
				res_q.rel_length <= '0;
				res_q.rel_ref    <= '0;
			end
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign res  = res_q;

	`RTPRB_ASSERT_IMP(a_done_idle, done_q, state_q == ST_IDLE)
	`RTPRB_ASSERT_IMP(a_chain_in_scan, chain_done, state_q == ST_SCAN)
	`RTPRB_ASSERT_NEXT(a_accept_eval, start && !busy, state_q == ST_EVAL)
	`RTPRB_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= CNT_W'(DEPTH))
	`RTPRB_ASSERT_NEXT(a_release_full, scan_go, fill_q >= eff)

endmodule
`default_nettype wire

FILE: rtl/rtprb_cell.sv
// One table cell: holds an entry and advances the release search by one step.
`default_nettype none
module rtprb_cell #(
	parameter int IDX_W = 5
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [IDX_W-1:0]     cell_idx,
	input  wire logic                 wr_en,
	input  wire rtprb_pkg::entry_t    wr_data,
	output rtprb_pkg::entry_t         entry,
	input  wire rtprb_pkg::scan_t     scan_in,
	input  wire logic [IDX_W-1:0]     idx1_in,
	input  wire logic [IDX_W-1:0]     idx2_in,
	output rtprb_pkg::scan_t          scan_out,
	output logic [IDX_W-1:0]          idx1_out,
	output logic [IDX_W-1:0]          idx2_out
);
	import rtprb_pkg::*;

	entry_t           entry_q;
	scan_t            cand_d;
	scan_t            cand_q;
	logic             valid_q;
	logic [IDX_W-1:0] idx1_d, idx2_d, idx1_q, idx2_q;
	logic             head;
	logic             take1, take2;

	// hold the entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q <= wr_data;
		end
	end

	assign entry = entry_q;
	assign head  = (cell_idx == '0);

	// only cell zero wins a tie, and only in the lowest-value search
	always_comb begin
		take1 = !scan_in.found1 || (entry_q.sq < scan_in.best1) ||
			(head && (entry_q.sq == scan_in.best1));
		take2 = entry_q.sq[15] && (!scan_in.found2 || (entry_q.sq < scan_in.best2));
		cand_d         = scan_in;
		idx1_d         = idx1_in;
		idx2_d         = idx2_in;
		cand_d.has_top = scan_in.has_top || (entry_q.sq == SEQ_TOP);
		if (take1) begin
			cand_d.found1 = 1'b1;
			cand_d.best1  = entry_q.sq;
			idx1_d        = cell_idx;
		end
		if (take2) begin
			cand_d.found2 = 1'b1;
			cand_d.best2  = entry_q.sq;
			idx2_d        = cell_idx;
		end
	end

	// advance the candidate to the lower neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= scan_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		cand_q <= cand_d;
		idx1_q <= idx1_d;
		idx2_q <= idx2_d;
	end

	always_comb begin
		scan_out       = cand_q;
		scan_out.valid = valid_q;
	end

	assign idx1_out = idx1_q;
	assign idx2_out = idx2_q;

endmodule
`default_nettype wire

FILE: tb/sv/rtp_reorder_buffer_checker.sv
`timescale 1ns / 1ps
// Checker for the RTP reorder buffer: tracks accepted items, predicts each result and compares.
module rtp_reorder_buffer_checker #(
	parameter int DEPTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  rtprb_pkg::item_t    pkt,
	input  logic                done,
	input  rtprb_pkg::result_t  res,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	input  logic [31:0]         prdata,
	input  logic                pready,
	output int                  fails,
	output int                  pending
);
	import rtprb_pkg::*;

	localparam logic [2:0]  DEPTH_ADDR = 3'(4 * REG_ACTIVE_DEPTH);
	localparam logic [15:0] SEQ_HALF   = 16'h7FFF;

	// Shadow of the table, the sequence tracker and the depth register
	entry_t      tab [DEPTH];
	int unsigned fill_cnt;
	logic [15:0] wrap_cnt;
	logic [15:0] last_seq;
	logic [31:0] last_src;
	logic [5:0]  depth_reg;
	result_t     outcome_q [$];
	result_t     want;
	int          mism = 0;

	initial begin
		fails = 0;
		pending = 0;
	end

	function automatic int unsigned live_depth();
		int unsigned d;
		d = depth_reg;
		if (d < 1) d = 1;
		if (d > DEPTH) d = DEPTH;
		return d;
	endfunction

	// Pick the entry to release: lowest sequence, or the lowest upper-half one once 65535 is held
	function automatic int unsigned victim_slot(int unsigned d);
		int unsigned idx;
		int unsigned best;
		logic        top_seen;
		idx = 0;
		best = tab[0].sq;
		top_seen = (tab[0].sq == SEQ_TOP);
		for (int i = int'(d) - 1; i >= 0; i--) begin
			if (tab[i].sq == SEQ_TOP) top_seen = 1'b1;
			if (tab[i].sq < best) begin
				best = tab[i].sq;
				idx = i;
			end
		end
		if (top_seen) begin
			best = 65536;
			for (int i = int'(d) - 1; i >= 0; i--) begin
				if (tab[i].sq > SEQ_HALF && tab[i].sq < best) begin
					best = tab[i].sq;
					idx = i;
				end
			end
		end
		return idx;
	endfunction

	// Work out the result of one packet and advance the shadow state
	function automatic result_t reorder_outcome(item_t it);
		result_t     r;
		int unsigned n_bytes;
		int unsigned d;
		int unsigned slot;
		logic        cut;
		r = '0;
		r.marker = it.second_byte[7];
		n_bytes = it.packet_length;
		cut = 1'b0;
		if (n_bytes < HDR_LEN) begin
			r.status = STAT_TOO_SHORT;
		end else if (it.first_byte[7:6] != RTP_VERSION) begin
			r.status = STAT_BAD_VER;
		end else begin
			// strip padding when the flag is set
			if (it.first_byte[5]) begin
				if (it.pad_count > n_bytes) cut = 1'b1;
				else n_bytes = n_bytes - it.pad_count;
				if (n_bytes < HDR_LEN) cut = 1'b1;
			end
			if (cut) begin
				r.status = STAT_TOO_SHORT;
			end else if (n_bytes - HDR_LEN > PAYLOAD_MAX) begin
				r.status = STAT_TOO_LONG;
			end else begin
				d = live_depth();
				last_src = it.source_id;
				if (it.seq_num == 16'd0) wrap_cnt = wrap_cnt + 16'd1;
				last_seq = it.seq_num;
				if (fill_cnt >= d) begin
					slot = victim_slot(d);
					r.status = STAT_RELEASED;
					r.rel_type = tab[slot].pt;
					r.rel_seq = tab[slot].sq;
					r.rel_time = tab[slot].ts;
					r.rel_length = tab[slot].len;
					r.rel_ref = tab[slot].pref;
				end else begin
					slot = fill_cnt;
					fill_cnt++;
					r.status = STAT_STORED;
				end
				tab[slot].pt = it.second_byte[6:0];
				tab[slot].sq = it.seq_num;
				tab[slot].ts = it.rtp_time;
				tab[slot].len = 12'(n_bytes - HDR_LEN);
				tab[slot].pref = it.payload_ref;
			end
		end
		r.ext_seq = {wrap_cnt, last_seq};
		r.last_source = last_src;
		return r;
	endfunction

	task automatic cmp_field(string fname, logic [31:0] exp_val, logic [31:0] got_val);
		if (got_val !== exp_val) begin
			mism++;
			if (mism <= 10)
				$display("%0t: %s mismatch: expected %h, got %h", $time, fname, exp_val,
					got_val);
		end
	endtask

	// Watch the channels; outputs move by nonblocking update so the stimulus side sees them
	// only after the edge has passed
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_cnt = 0;
			wrap_cnt = '0;
			last_seq = '0;
			last_src = '0;
			depth_reg = ACTIVE_DEPTH_RESET;
			outcome_q.delete();
			pending <= 0;
			fails <= mism;
		end else begin
			// compare a result with the oldest prediction
			if (done) begin
				if (outcome_q.size() == 0) begin
					mism++;
					if (mism <= 10) $display("%0t: result with no item outstanding", $time);
				end else begin
					want = outcome_q.pop_front();
					cmp_field("status", 32'(want.status), 32'(res.status));
					cmp_field("rel_type", 32'(want.rel_type), 32'(res.rel_type));
					cmp_field("rel_seq", 32'(want.rel_seq), 32'(res.rel_seq));
					cmp_field("rel_time", want.rel_time, res.rel_time);
					cmp_field("rel_length", 32'(want.rel_length), 32'(res.rel_length));
					cmp_field("rel_ref", 32'(want.rel_ref), 32'(res.rel_ref));
					cmp_field("ext_seq", want.ext_seq, res.ext_seq);
					cmp_field("last_source", want.last_source, res.last_source);
					cmp_field("marker", 32'(want.marker), 32'(res.marker));
				end
			end
			// predict each accepted item
			if (start && !busy) outcome_q.push_back(reorder_outcome(pkt));
			// follow register writes and check reads
			if (psel && penable && pready && paddr == DEPTH_ADDR) begin
				if (pwrite) depth_reg = pwdata[5:0];
				else cmp_field("prdata", 32'(depth_reg), prdata);
			end
			pending <= outcome_q.size();
			fails <= mism;
		end
	end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Stimulus, watchdog and verdict for the RTP reorder buffer testbench.
module tb_top;
	import rtprb_pkg::*;

	localparam int          DEPTH         = 32;
	localparam int          IDLE_LIMIT    = 4000;
	localparam int          SETTLE_CYCLES = DEPTH + 8;
	localparam int          PHASES        = 10;
	localparam int          PHASE_ITEMS   = 170;
	localparam logic [2:0]  DEPTH_ADDR    = 3'(4 * REG_ACTIVE_DEPTH);

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	item_t       pkt = '0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic        busy;
	logic        done;
	result_t     res;
	logic [31:0] prdata;
	logic        pready;
	int          fails;
	int          pending;
	int          idle_cycles = 0;

	// Sequence stream state
	logic [15:0] seq_base = '0;
	logic [31:0] cur_source = '0;

	logic [5:0]  depth_plan [PHASES] = '{6'd32, 6'd5, 6'd0, 6'd63, 6'd1, 6'd17, 6'd2,
		6'd48, 6'd32, 6'd8};

	always #6 clk = ~clk;

	rtp_reorder_buffer #(.DEPTH(DEPTH)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .pkt(pkt), .done(done),
		.res(res), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	rtp_reorder_buffer_checker #(.DEPTH(DEPTH)) chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .pkt(pkt), .done(done),
		.res(res), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready), .fails(fails), .pending(pending)
	);

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[rtp_reorder_buffer] ERROR");
				$finish;
			end
		end
	end

	function automatic item_t hdr(logic [7:0] fb, logic [7:0] sb, logic [15:0] sq,
		int unsigned n_bytes, logic [7:0] pad);
		item_t it;
		it.first_byte = fb;
		it.second_byte = sb;
		it.seq_num = sq;
		it.rtp_time = $urandom;
		it.source_id = $urandom;
		it.packet_length = 12'(n_bytes);
		it.pad_count = pad;
		it.payload_ref = 16'($urandom);
		return it;
	endfunction

	// Well-formed packet of the current stream, mostly small payloads
	function automatic item_t good_packet(logic [15:0] sq);
		item_t       it;
		int unsigned plen;
		int unsigned pad;
		case ($urandom_range(0, 9))
			0: plen = PAYLOAD_MAX;
			1: plen = 0;
			2, 3: plen = $urandom_range(0, PAYLOAD_MAX);
			default: plen = $urandom_range(0, 200);
		endcase
		pad = $urandom_range(0, 255);
		it = hdr({2'b10, 1'($urandom), 5'($urandom)}, 8'($urandom), sq, 0, 8'(pad));
		it.source_id = cur_source;
		it.packet_length = it.first_byte[5] ? 12'(HDR_LEN + plen + pad) : 12'(HDR_LEN + plen);
		return it;
	endfunction

	// Malformed packet of one of the drop kinds
	function automatic item_t bad_packet(logic [15:0] sq);
		item_t       it;
		int unsigned n_bytes;
		int unsigned ver;
		it = good_packet(sq);
		case ($urandom_range(0, 4))
			0: it.packet_length = 12'($urandom_range(0, HDR_LEN - 1));
			1: begin
				ver = $urandom_range(0, 2);
				if (ver == 2) ver = 3;
				it.first_byte[7:6] = 2'(ver);
				it.packet_length = 12'($urandom_range(HDR_LEN, 4095));
			end
			2: begin
				n_bytes = $urandom_range(HDR_LEN, 254);
				it.first_byte[5] = 1'b1;
				it.packet_length = 12'(n_bytes);
				it.pad_count = 8'($urandom_range(n_bytes + 1, 255));
			end
			3: begin
				n_bytes = $urandom_range(HDR_LEN, 255);
				it.first_byte[5] = 1'b1;
				it.packet_length = 12'(n_bytes);
				it.pad_count = 8'($urandom_range(n_bytes - HDR_LEN + 1, n_bytes));
			end
			default: begin
				n_bytes = HDR_LEN + PAYLOAD_MAX + 1 + (it.first_byte[5] ? it.pad_count : 0);
				it.packet_length = 12'($urandom_range(n_bytes, 4095));
			end
		endcase
		return it;
	endfunction

	// Mostly advancing sequence numbers with small reordering, some jumps
	function automatic logic [15:0] next_seq();
		logic [15:0] sq;
		case ($urandom_range(0, 99))
			0: sq = SEQ_TOP;
			1: sq = 16'd0;
			2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13: sq = 16'($urandom);
			default: sq = seq_base + 16'($urandom_range(0, 7)) - 16'd3;
		endcase
		seq_base = seq_base + 16'd1;
		return sq;
	endfunction

	function automatic int unsigned gap_len();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 88) return $urandom_range(1, 3);
		if (p < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offer one item and hold it until the block takes it
	task automatic push_item(input item_t it);
		start <= 1'b1;
		pkt <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic idle(input int unsigned n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every predicted result has come
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= DEPTH_ADDR;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Write the depth register once idle, then read it back
	task automatic set_depth(input logic [5:0] dv);
		drain();
		apb_access(1'b1, {26'($urandom), dv});
		apb_access(1'b0, '0);
	endtask

	task automatic run_phase(input logic [5:0] dv, input logic no_gaps, input logic hold_mid);
		set_depth(dv);
		seq_base = ($urandom_range(0, 2) == 0) ? 16'(65536 - $urandom_range(20, 120))
			: 16'($urandom);
		cur_source = $urandom;
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			if (hold_mid && i == PHASE_ITEMS / 2) drain();
			if ($urandom_range(0, 49) == 0) cur_source = $urandom;
			if (!no_gaps) idle(gap_len());
			if ($urandom_range(0, 9) < 8) push_item(good_packet(next_seq()));
			else push_item(bad_packet(next_seq()));
		end
	endtask

	initial begin
		item_t it;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// read the reset value, then a small table for the directed packets
		apb_access(1'b0, '0);
		set_depth(6'd3);

		// drops: every kind, field extremes
		it = hdr(8'hFF, 8'hFF, SEQ_TOP, 0, 8'hFF);
		it.rtp_time = '1;
		it.source_id = '1;
		it.payload_ref = '1;
		push_item(it);
		it = hdr(8'h80, 8'h00, 16'd0, HDR_LEN - 1, 8'h00);
		it.rtp_time = '0;
		it.source_id = '0;
		it.payload_ref = '0;
		push_item(it);
		push_item(hdr(8'h00, 8'h80, 16'd5, HDR_LEN, 8'h00));
		push_item(hdr(8'h40, 8'h12, 16'd6, 4095, 8'h00));
		push_item(hdr(8'hC0, 8'h93, 16'd7, 100, 8'h00));
		push_item(hdr(8'hA0, 8'h7F, 16'd8, HDR_LEN, 8'hFF));
		push_item(hdr(8'hA0, 8'h05, 16'd9, 40, 8'd30));
		push_item(hdr(8'h80, 8'h81, 16'd10, HDR_LEN + PAYLOAD_MAX + 1, 8'h00));
		push_item(hdr(8'hBF, 8'h22, 16'd11, 4095, 8'h00));

		// fill the table: largest payload after padding, wrap on zero, top sequence
		push_item(hdr(8'hA0, 8'hE0, 16'd100, HDR_LEN + PAYLOAD_MAX + 255, 8'hFF));
		push_item(hdr(8'h9F, 8'h01, 16'd0, HDR_LEN, 8'hFF));
		it = hdr(8'hA5, 8'hFF, SEQ_TOP, HDR_LEN + 12, 8'd12);
		it.rtp_time = '1;
		it.source_id = '1;
		it.payload_ref = '1;
		push_item(it);

		// releases: top-sequence rule, plain minimum, ties on both scans
		push_item(hdr(8'h80, 8'h60, 16'd40000, 30, 8'h00));
		push_item(hdr(8'h80, 8'h8A, 16'd1, 31, 8'h00));
		push_item(hdr(8'h80, 8'h0B, SEQ_TOP, 32, 8'h00));
		push_item(hdr(8'h80, 8'h8C, SEQ_TOP, 33, 8'h00));
		push_item(hdr(8'h80, 8'h0D, 16'd50, 34, 8'h00));
		push_item(hdr(8'h80, 8'h8E, 16'd50, 35, 8'h00));
		push_item(hdr(8'h80, 8'h0F, 16'd60, 36, 8'h00));

		// random phases over the depth settings; one without gaps, one with a full pause
		for (int ph = 0; ph < PHASES; ph++)
			run_phase(depth_plan[ph], ph == 3, ph == 1);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("[rtp_reorder_buffer] OK");
		else
			$display("[rtp_reorder_buffer] ERROR");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/rtprb_pkg.sv
rtl/rtprb_cell.sv
rtl/rtp_reorder_buffer.sv
tb/sv/rtp_reorder_buffer_checker.sv
tb/sv/tb_top.sv
